// ===== rtl/dmx_upm_pkg.sv =====
// ============================================================================
// DMX universe pixel mapper package
// Shared types, register map, command codes and arithmetic helpers.
// ============================================================================
package dmx_upm_pkg;

    localparam int SETUP_REGS = 4;
    localparam int SETUP_W    = 36;
    localparam int LANE_W     = 8;
    localparam int PIXEL_W    = 24;

    localparam logic [2:0] REG_STRIP0 = 3'd0;
    localparam logic [2:0] REG_STRIP1 = 3'd1;
    localparam logic [2:0] REG_STRIP2 = 3'd2;
    localparam logic [2:0] REG_STRIP3 = 3'd3;
    localparam logic [2:0] REG_BRIGHT = 3'd4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_FOLD2 = 3'd1;
    localparam logic [2:0] MODE_PAR2  = 3'd2;
    localparam logic [2:0] MODE_PAR3  = 3'd3;

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    typedef struct packed {
        logic [2:0] partner2;
        logic [2:0] partner1;
        logic [2:0] mode;
        logic [9:0] led_count;
        logic [8:0] offset;
        logic [7:0] start_uni;
    } t_setup;

    typedef struct packed {
        logic        hit;
        logic [11:0] led;
        logic [1:0]  comp;
    } t_lane_pos;

    typedef struct packed {
        logic        hit;
        logic [2:0]  strip;
        logic [10:0] pix;
        logic [1:0]  comp;
    } t_wreq;

    typedef struct packed {
        logic [2:0]        wen;
        logic [LANE_W-1:0] data;
    } t_bank_wr;

    function automatic logic [12:0] div3(input logic [13:0] x);
        logic [29:0] prod;
        prod = {16'b0, x} * 30'd43691;
        return prod[29:17];
    endfunction

    function automatic t_lane_pos place_byte(input t_setup su, input logic [7:0] uni,
                                             input logic [8:0] pos, input logic [9:0] len);
        logic        hit;
        logic [11:0] virt;
        logic [13:0] total;
        logic [7:0]  diff;
        logic [16:0] sb;
        logic [8:0]  q;
        logic [9:0]  len_rem;
        logic [13:0] rem;
        logic [13:0] usable;
        logic [12:0] base;
        logic [12:0] tq;
        logic [7:0]  t;
        logic [8:0]  t3;
        logic [8:0]  qr;
        logic [13:0] last;
        logic [13:0] v;
        t_lane_pos   res;
        hit     = 1'b1;
        virt    = '0;
        q       = '0;
        usable  = '0;
        base    = '0;
        diff    = '0;
        sb      = '0;
        len_rem = '0;
        rem     = '0;
        unique case (su.mode)
            MODE_NONE, MODE_FOLD2: virt = {2'b0, su.led_count};
            MODE_PAR2: virt = {1'b0, su.led_count, 1'b0};
            MODE_PAR3: virt = {2'b0, su.led_count} + {1'b0, su.led_count, 1'b0};
            default:   hit = 1'b0;
        endcase
        total = {2'b0, virt} + {1'b0, virt, 1'b0};
        if (uni < su.start_uni) begin
            hit = 1'b0;
        end else if (uni == su.start_uni) begin
            if (len <= {1'b0, su.offset} || pos < su.offset) begin
                hit = 1'b0;
            end
            q       = pos - su.offset;
            len_rem = len - {1'b0, su.offset};
            usable  = ({4'b0, len_rem} > total) ? total : {4'b0, len_rem};
        end else begin
            diff = uni - su.start_uni;
            sb   = {diff, 9'b0} - {8'b0, su.offset};
            if (sb >= {3'b0, total}) begin
                hit = 1'b0;
            end
            q      = pos;
            rem    = total - sb[13:0];
            usable = ({4'b0, len} > rem) ? rem : {4'b0, len};
            base   = div3(sb[13:0]);
        end
        tq   = div3({5'b0, q});
        t    = tq[7:0];
        t3   = {1'b0, t} + {t, 1'b0};
        qr   = q - t3;
        last = {5'b0, t3} + 14'd2;
        if (last >= usable) begin
            hit = 1'b0;
        end
        v = {1'b0, base} + {6'b0, t};
        if (v >= {2'b0, virt}) begin
            hit = 1'b0;
        end
        res.hit  = hit;
        res.led  = v[11:0];
        res.comp = qr[1:0];
        return res;
    endfunction

    function automatic t_wreq remap(input t_setup su, input logic [2:0] self,
                                    input t_lane_pos lp);
        logic [10:0] half;
        logic [12:0] d;
        logic [11:0] r12;
        t_wreq       res;
        half      = lp.led[11:1];
        d         = div3({2'b0, lp.led});
        r12       = lp.led - (d[11:0] + {d[10:0], 1'b0});
        res.hit   = lp.hit;
        res.comp  = lp.comp;
        res.strip = self;
        res.pix   = {1'b0, lp.led[9:0]};
        unique case (su.mode)
            MODE_NONE: res.pix = lp.led[10:0];
            MODE_FOLD2: begin
                res.pix = lp.led[0] ? ({1'b0, su.led_count} - 11'd1 - half) : half;
            end
            MODE_PAR2: begin
                res.strip = lp.led[0] ? su.partner1 : self;
                res.pix   = half;
            end
            MODE_PAR3: begin
                unique case (r12[1:0])
                    2'd0:    res.strip = self;
                    2'd1:    res.strip = su.partner1;
                    default: res.strip = su.partner2;
                endcase
                res.pix = d[10:0];
            end
            default: res.hit = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/dmx_upm_bank.sv =====
// ============================================================================
// DMX mapper pixel bank
// One physical strip of pixels, stored as three byte lanes with a shared
// write address, per-lane write enables and a registered read port.
// ============================================================================
module dmx_upm_bank #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                          i_clk,
    input  dmx_upm_pkg::t_bank_wr         i_wr,
    input  logic [AW-1:0]                 i_waddr,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [dmx_upm_pkg::PIXEL_W-1:0] o_rdata
);

    logic [dmx_upm_pkg::LANE_W-1:0] r_red   [DEPTH];
    logic [dmx_upm_pkg::LANE_W-1:0] r_green [DEPTH];
    logic [dmx_upm_pkg::LANE_W-1:0] r_blue  [DEPTH];
    logic [dmx_upm_pkg::PIXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.wen[dmx_upm_pkg::LANE_RED]) begin
            r_red[i_waddr] <= i_wr.data;
        end
        if (i_wr.wen[dmx_upm_pkg::LANE_GREEN]) begin
            r_green[i_waddr] <= i_wr.data;
        end
        if (i_wr.wen[dmx_upm_pkg::LANE_BLUE]) begin
            r_blue[i_waddr] <= i_wr.data;
        end
        if (i_re) begin
            r_rdata <= {r_red[i_raddr], r_green[i_raddr], r_blue[i_raddr]};
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dmx_universe_pixel_mapper.sv =====
// ============================================================================
// DMX universe pixel mapper
// Places DMX universe bytes into RGB pixel banks per strip and resolution
// mode, and returns stored pixels with the global brightness on read.
// ============================================================================
// Pipeline: input register, then placement register; a read then registers the
// bank word with the output valid, and a byte write goes from placement into the banks.
// Throughput: one transaction per cycle unless the output is held or a byte's
// strips share a physical bank, which takes one write at a time (single write port).
// Reset: setups clear, brightness goes to 255, then a clearing pass through all
// MAX_PIXELS addresses zeroes all banks while s_axis_tready stays low.
module dmx_universe_pixel_mapper #(
    parameter int STRIP_COUNT = 4,
    parameter int MAX_PIXELS  = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] universe, [16:8] byte_position, [26:17] packet_length,
    // [34:27] byte_value, [36:35] read_strip, [45:37] read_pixel, [47:46] zero
    input  logic [47:0] s_axis_tdata,
    // [0] command
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] brightness
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SW    = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1;

    // configuration
    dmx_upm_pkg::t_setup r_setup [dmx_upm_pkg::SETUP_REGS];
    logic [7:0]          r_bright;
    logic [2:0]          reg_idx;
    logic                cfg_wr;

    // clearing pass
    logic             r_clr_busy;
    logic [PIX_W-1:0] r_clr_cnt;

    // input stage
    logic        r_a_valid;
    logic        r_a_cmd;
    logic [45:0] r_a_data;
    logic [7:0]  a_uni;
    logic [8:0]  a_pos;
    logic [9:0]  a_len;
    logic [1:0]  a_rs;
    logic [8:0]  a_rp;
    logic        a_free;

    // placement stage
    logic                   r_p_valid;
    logic                   r_p_cmd;
    logic [7:0]             r_p_val;
    dmx_upm_pkg::t_lane_pos r_p_lane [STRIP_COUNT];
    logic                   r_p_rd_ok;
    logic [SW-1:0]          r_p_rd_strip;
    logic [PIX_W-1:0]       r_p_rd_addr;
    logic [STRIP_COUNT-1:0] r_done;
    logic                   p_go;
    logic                   rd_issue;

    dmx_upm_pkg::t_wreq     req [STRIP_COUNT];
    logic [STRIP_COUNT-1:0] active;
    logic [STRIP_COUNT-1:0] grant;

    // output stage
    logic          r_o_valid;
    logic          r_o_zero;
    logic [SW-1:0] r_o_strip;
    logic [23:0]   px;

    dmx_upm_pkg::t_bank_wr bank_wr    [STRIP_COUNT];
    logic [PIX_W-1:0]      bank_waddr [STRIP_COUNT];
    logic [STRIP_COUNT-1:0] bank_re;
    logic [23:0]           bank_rdata [STRIP_COUNT];

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dmx_upm_pkg::SETUP_REGS; i++) begin
                r_setup[i] <= '0;
            end
            r_bright <= 8'd255;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                dmx_upm_pkg::REG_STRIP0: r_setup[0] <= pwdata[35:0];
                dmx_upm_pkg::REG_STRIP1: r_setup[1] <= pwdata[35:0];
                dmx_upm_pkg::REG_STRIP2: r_setup[2] <= pwdata[35:0];
                dmx_upm_pkg::REG_STRIP3: r_setup[3] <= pwdata[35:0];
                dmx_upm_pkg::REG_BRIGHT: r_bright   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dmx_upm_pkg::REG_STRIP0: prdata = {28'b0, r_setup[0]};
            dmx_upm_pkg::REG_STRIP1: prdata = {28'b0, r_setup[1]};
            dmx_upm_pkg::REG_STRIP2: prdata = {28'b0, r_setup[2]};
            dmx_upm_pkg::REG_STRIP3: prdata = {28'b0, r_setup[3]};
            dmx_upm_pkg::REG_BRIGHT: prdata = {56'b0, r_bright};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Clearing pass
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == PIX_W'(MAX_PIXELS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------
    assign a_free        = !r_a_valid || p_go;
    assign s_axis_tready = !r_clr_busy && a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= s_axis_tvalid && !r_clr_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_a_cmd  <= s_axis_tuser[0];
            r_a_data <= s_axis_tdata[45:0];
        end
    end

    assign a_uni = r_a_data[7:0];
    assign a_pos = r_a_data[16:8];
    assign a_len = r_a_data[26:17];
    assign a_rs  = r_a_data[36:35];
    assign a_rp  = r_a_data[45:37];

    // ------------------------------------------------------------------
    // Placement stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_go) begin
            r_p_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_go) begin
            r_p_cmd      <= r_a_cmd;
            r_p_val      <= r_a_data[34:27];
            r_p_rd_ok    <= ({1'b0, a_rs} < 3'(STRIP_COUNT))
                         && ({2'b0, a_rp} < 11'(MAX_PIXELS));
            r_p_rd_strip <= a_rs[SW-1:0];
            r_p_rd_addr  <= PIX_W'({2'b0, a_rp});
            for (int s = 0; s < STRIP_COUNT; s++) begin
                r_p_lane[s] <= dmx_upm_pkg::place_byte(r_setup[s], a_uni, a_pos, a_len);
            end
        end
    end

    always_comb begin
        for (int s = 0; s < STRIP_COUNT; s++) begin
            req[s]    = dmx_upm_pkg::remap(r_setup[s], 3'(s), r_p_lane[s]);
            active[s] = r_p_valid && (r_p_cmd == dmx_upm_pkg::CMD_WRITE) && req[s].hit
                     && (req[s].strip < 3'(STRIP_COUNT)) && (req[s].pix < 11'(MAX_PIXELS))
                     && !r_done[s];
        end
    end

    // lowest strip first into each bank, so later strips overwrite
    always_comb begin
        logic [STRIP_COUNT-1:0] taken;
        taken = '0;
        grant = '0;
        for (int b = 0; b < STRIP_COUNT; b++) begin
            bank_wr[b].wen  = '0;
            bank_wr[b].data = r_p_val;
            bank_waddr[b]   = '0;
            for (int s = 0; s < STRIP_COUNT; s++) begin
                if (!taken[b] && active[s] && (req[s].strip == 3'(b))) begin
                    taken[b]        = 1'b1;
                    grant[s]        = 1'b1;
                    bank_wr[b].wen  = 3'b001 << req[s].comp;
                    bank_waddr[b]   = req[s].pix[PIX_W-1:0];
                end
            end
            if (r_clr_busy) begin
                bank_wr[b].wen  = 3'b111;
                bank_wr[b].data = '0;
                bank_waddr[b]   = r_clr_cnt;
            end
        end
    end

    always_comb begin
        if (!r_p_valid) begin
            p_go = 1'b1;
        end else if (r_p_cmd == dmx_upm_pkg::CMD_READ) begin
            p_go = !r_o_valid || m_axis_tready;
        end else begin
            p_go = (active & ~grant) == '0;
        end
    end

    assign rd_issue = r_p_valid && (r_p_cmd == dmx_upm_pkg::CMD_READ) && p_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (p_go) begin
            r_done <= '0;
        end else begin
            r_done <= r_done | grant;
        end
    end

    // ------------------------------------------------------------------
    // Pixel banks
    // ------------------------------------------------------------------
    for (genvar b = 0; b < STRIP_COUNT; b++) begin : g_bank
        assign bank_re[b] = rd_issue && r_p_rd_ok && (r_p_rd_strip == SW'(b));

        dmx_upm_bank #(
            .DEPTH (MAX_PIXELS),
            .AW    (PIX_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_wr    (bank_wr[b]),
            .i_waddr (bank_waddr[b]),
            .i_re    (bank_re[b]),
            .i_raddr (r_p_rd_addr),
            .o_rdata (bank_rdata[b])
        );
    end

    // ------------------------------------------------------------------
    // Output stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!r_o_valid || m_axis_tready) begin
            r_o_valid <= rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_o_zero  <= !r_p_rd_ok;
            r_o_strip <= r_p_rd_strip;
        end
    end

    assign px            = r_o_zero ? 24'd0 : bank_rdata[r_o_strip];
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_bright, px[7:0], px[15:8], px[23:16]};

endmodule
